### design/lcrc_pkg.sv
// Package for the LED current range and code unit: constants, tables, microcode.
`default_nettype none
package lcrc_pkg;

  localparam int NUM_RANGES = 8;
  localparam int CODE_BITS  = 12;

  localparam int LOAD_W  = 22;
  localparam int LIMIT_W = 22;
  localparam int REXT_W  = 20;
  localparam int VMAX_W  = 16;
  localparam int BASE_W  = 16;
  localparam int SEL_W   = 3;
  localparam int STAT_W  = 2;
  localparam int CIDX_W  = 2;
  localparam int PC_W    = 4;

  // Divider: dividend wide enough for the code product and the 32-bit limit
  // product, quotient grows in place, one bit per cycle.
  localparam int NUM_W     = (LOAD_W + CODE_BITS > 32) ? LOAD_W + CODE_BITS : 32;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = 6;

  localparam logic [LIMIT_W-1:0]   LIMIT_MAX  = {LIMIT_W{1'b1}};
  localparam logic [CODE_BITS-1:0] FULL_SCALE = {CODE_BITS{1'b1}};
  localparam logic [SEL_W-1:0]     LAST_IDX   = SEL_W'(NUM_RANGES - 1);
  localparam logic [BASE_W-1:0]    BASE_TOP   = 16'd50000;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_EXT_R   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_VAR_MAX = 2'd1;
  localparam logic [CIDX_W-1:0] REG_EXT_EN  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVER = 2'd1;
  localparam logic [STAT_W-1:0] ST_CLIP = 2'd2;

  // Microcode operations
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_REC_INIT = 4'd1;
  localparam logic [3:0] OP_LMUL     = 4'd2;
  localparam logic [3:0] OP_DIV      = 4'd3;
  localparam logic [3:0] OP_LSTORE   = 4'd4;
  localparam logic [3:0] OP_IDLE     = 4'd5;
  localparam logic [3:0] OP_SCAN    = 4'd6;
  localparam logic [3:0] OP_CMUL     = 4'd7;
  localparam logic [3:0] OP_SETCODE  = 4'd8;
  localparam logic [3:0] OP_FIXED    = 4'd9;
  localparam logic [3:0] OP_CLIP     = 4'd10;
  localparam logic [3:0] OP_ERR      = 4'd11;
  localparam logic [3:0] OP_OUT      = 4'd12;

  // Jump conditions (jump to target when true, else fall through)
  localparam logic [3:0] C_NONE        = 4'd0;
  localparam logic [3:0] C_ALWAYS      = 4'd1;
  localparam logic [3:0] C_DIV_BUSY    = 4'd2;
  localparam logic [3:0] C_NOT_LAST    = 4'd3;
  localparam logic [3:0] C_NO_ACCEPT   = 4'd4;
  localparam logic [3:0] C_FIXED_MODE  = 4'd5;
  localparam logic [3:0] C_SCAN_MISS   = 4'd6;
  localparam logic [3:0] C_NO_HIT      = 4'd7;
  localparam logic [3:0] C_NOT_OVER    = 4'd8;
  localparam logic [3:0] C_OUT_BLOCKED = 4'd9;

  // Program addresses
  localparam logic [PC_W-1:0] PC_REC_INIT = 4'd0;
  localparam logic [PC_W-1:0] PC_LMUL     = 4'd1;
  localparam logic [PC_W-1:0] PC_LDIV     = 4'd2;
  localparam logic [PC_W-1:0] PC_LSTORE   = 4'd3;
  localparam logic [PC_W-1:0] PC_IDLE     = 4'd4;
  localparam logic [PC_W-1:0] PC_BRANCH   = 4'd5;
  localparam logic [PC_W-1:0] PC_SCAN     = 4'd6;
  localparam logic [PC_W-1:0] PC_CHECK    = 4'd7;
  localparam logic [PC_W-1:0] PC_CMUL     = 4'd8;
  localparam logic [PC_W-1:0] PC_CDIV     = 4'd9;
  localparam logic [PC_W-1:0] PC_SETCODE  = 4'd10;
  localparam logic [PC_W-1:0] PC_FIXED    = 4'd11;
  localparam logic [PC_W-1:0] PC_CLIP     = 4'd12;
  localparam logic [PC_W-1:0] PC_ERR      = 4'd13;
  localparam logic [PC_W-1:0] PC_OUT      = 4'd14;
  localparam logic [PC_W-1:0] PC_GOTO     = 4'd15;

  typedef struct packed {
    logic [3:0]      op;
    logic [3:0]      cond;
    logic [PC_W-1:0] target;
  } ucw_t;

  function automatic logic [BASE_W-1:0] base_limit(input logic [SEL_W-1:0] idx);
    logic [BASE_W-1:0] v;
    case (idx)
      3'd0:    v = 16'd5000;
      3'd1:    v = 16'd10000;
      3'd2:    v = 16'd15000;
      3'd3:    v = 16'd20000;
      3'd4:    v = 16'd23000;
      3'd5:    v = 16'd25000;
      3'd6:    v = 16'd30000;
      default: v = BASE_TOP;
    endcase
    return v;
  endfunction

  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    case (pc)
      PC_REC_INIT: w = '{OP_REC_INIT, C_NONE,        PC_LMUL};
      PC_LMUL:     w = '{OP_LMUL,     C_NONE,        PC_LDIV};
      PC_LDIV:     w = '{OP_DIV,      C_DIV_BUSY,    PC_LDIV};
      PC_LSTORE:   w = '{OP_LSTORE,   C_NOT_LAST,    PC_LMUL};
      PC_IDLE:     w = '{OP_IDLE,     C_NO_ACCEPT,   PC_IDLE};
      PC_BRANCH:   w = '{OP_NOP,      C_FIXED_MODE,  PC_FIXED};
      PC_SCAN:     w = '{OP_SCAN,     C_SCAN_MISS,   PC_SCAN};
      PC_CHECK:    w = '{OP_NOP,      C_NO_HIT,      PC_ERR};
      PC_CMUL:     w = '{OP_CMUL,     C_NONE,        PC_CDIV};
      PC_CDIV:     w = '{OP_DIV,      C_DIV_BUSY,    PC_CDIV};
      PC_SETCODE:  w = '{OP_SETCODE,  C_ALWAYS,      PC_OUT};
      PC_FIXED:    w = '{OP_FIXED,    C_NOT_OVER,    PC_CMUL};
      PC_CLIP:     w = '{OP_CLIP,     C_ALWAYS,      PC_OUT};
      PC_ERR:      w = '{OP_ERR,      C_NONE,        PC_OUT};
      PC_OUT:      w = '{OP_OUT,      C_OUT_BLOCKED, PC_OUT};
      PC_GOTO:     w = '{OP_NOP,      C_ALWAYS,      PC_IDLE};
      default:     w = '{OP_NOP,      C_ALWAYS,      PC_REC_INIT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### design/led_current_range_and_code_unit.sv
// LED current range and code unit: microcoded sequencer with a shared serial divider.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+------------------------------------------
//  in_       | in  | in_tvalid/tready   | in_tdata: load_ua[21:0]
//  out_      | out | out_tvalid/tready  | out_tdata: set0_byte[7:0], set1_byte[14:8],
//            |     |                    |            status[16:15]
//  cfg_      | in  | cfg_wr_en          | cfg_index (0 ext R, 1 variant max, 2 enable)
//
// Paths: scaled mode scans n = 1..8 limits, then runs the serial divide;
//   fixed range skips the scan and runs the divide, while a clipped request
//   or one with no limit above it skips the divide and goes to the output step.
// Reset and every write to a known register run the limit recompute program
//   for all 8 limits with in_tready low.
// A full output register holds the sequencer at its output step until taken.
`default_nettype none
module led_current_range_and_code_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,    // [21:0] load_ua, [23:22] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,   // [7:0] set0_byte, [14:8] set1_byte,
                                        // [16:15] status, [23:17] zero
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_wdata
);

  // Configuration registers
  logic [lcrc_pkg::REXT_W-1:0] rext_r, rext_nxt;
  logic [lcrc_pkg::VMAX_W-1:0] vmax_r, vmax_nxt;
  logic                        en_r, en_nxt;

  // Sequencer
  logic [lcrc_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic [lcrc_pkg::SEL_W-1:0]  idx_r, idx_nxt;
  lcrc_pkg::ucw_t              uw;
  logic                        cond_true;

  // Datapath
  logic [lcrc_pkg::LOAD_W-1:0]  load_r, load_nxt;
  logic [lcrc_pkg::NUM_W-1:0]   num_r, num_nxt;      // dividend, becomes quotient
  logic [lcrc_pkg::LIMIT_W-1:0] rem_r, rem_nxt;
  logic [lcrc_pkg::LIMIT_W-1:0] den_r, den_nxt;
  logic [lcrc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [lcrc_pkg::LIMIT_W-1:0] limits_r [lcrc_pkg::NUM_RANGES];
  logic [lcrc_pkg::LIMIT_W-1:0] limits_nxt [lcrc_pkg::NUM_RANGES];

  // Result and output register
  logic [lcrc_pkg::CODE_BITS-1:0] code_r, code_nxt;
  logic [lcrc_pkg::SEL_W-1:0]     sel_r, sel_nxt;
  logic [lcrc_pkg::STAT_W-1:0]    stat_r, stat_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [23:0]                    out_data_r, out_data_nxt;

  // Combinational helpers
  logic                         in_xfer;
  logic                         hit;
  logic [lcrc_pkg::LIMIT_W-1:0] cur_limit;
  logic [lcrc_pkg::LIMIT_W-1:0] fixed_limit;
  logic [31:0]                  lim_prod;
  logic [lcrc_pkg::NUM_W-1:0]   code_prod;
  logic [lcrc_pkg::LIMIT_W:0]   rem_sh;
  logic                         rem_ge;
  logic                         out_blocked;
  logic [15:0]                  code_ext;

  assign uw          = lcrc_pkg::ucode(pc_r);
  assign in_tready   = (pc_r == lcrc_pkg::PC_IDLE) && !cfg_wr_en;
  assign in_xfer     = in_tvalid && in_tready;
  assign cur_limit   = limits_r[idx_r];
  assign hit         = load_r < cur_limit;
  assign out_blocked = out_valid_r && !out_tready;
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;
  assign code_ext    = 16'(code_r);

  // Fixed mode uses the top range's base limit
  assign fixed_limit = lcrc_pkg::LIMIT_W'(lcrc_pkg::base_limit(lcrc_pkg::LAST_IDX));

  // One multiplier per operation kind; each feeds a register.
  assign lim_prod  = 32'(lcrc_pkg::base_limit(idx_r)) * 32'(vmax_r);
  assign code_prod = lcrc_pkg::NUM_W'(lcrc_pkg::FULL_SCALE) * lcrc_pkg::NUM_W'(load_r);

  // Restoring divide step
  assign rem_sh = {rem_r, num_r[lcrc_pkg::NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, den_r};

  always_comb begin
    case (uw.cond)
      lcrc_pkg::C_NONE:        cond_true = 1'b0;
      lcrc_pkg::C_ALWAYS:      cond_true = 1'b1;
      lcrc_pkg::C_DIV_BUSY:    cond_true = cnt_r != lcrc_pkg::CNT_W'(1);
      lcrc_pkg::C_NOT_LAST:    cond_true = idx_r != lcrc_pkg::LAST_IDX;
      lcrc_pkg::C_NO_ACCEPT:   cond_true = !in_xfer;
      lcrc_pkg::C_FIXED_MODE:  cond_true = !en_r;
      lcrc_pkg::C_SCAN_MISS:   cond_true = !hit && (idx_r != lcrc_pkg::LAST_IDX);
      lcrc_pkg::C_NO_HIT:      cond_true = !hit;
      lcrc_pkg::C_NOT_OVER:    cond_true = load_r <= fixed_limit;
      lcrc_pkg::C_OUT_BLOCKED: cond_true = out_blocked;
      default:                 cond_true = 1'b0;
    endcase
  end

  always_comb begin
    rext_nxt      = rext_r;
    vmax_nxt      = vmax_r;
    en_nxt        = en_r;
    idx_nxt       = idx_r;
    load_nxt      = load_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    cnt_nxt       = cnt_r;
    limits_nxt    = limits_r;
    code_nxt      = code_r;
    sel_nxt       = sel_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    pc_nxt        = cond_true ? uw.target : pc_r + lcrc_pkg::PC_W'(1);

    case (uw.op)
      lcrc_pkg::OP_REC_INIT: begin
        idx_nxt = '0;
      end
      lcrc_pkg::OP_LMUL: begin
        num_nxt = lcrc_pkg::NUM_W'(lim_prod);
        den_nxt = lcrc_pkg::LIMIT_W'(rext_r);
        rem_nxt = '0;
        cnt_nxt = lcrc_pkg::CNT_W'(lcrc_pkg::DIV_STEPS);
      end
      lcrc_pkg::OP_DIV: begin
        rem_nxt = rem_ge ? lcrc_pkg::LIMIT_W'(rem_sh - {1'b0, den_r})
                         : rem_sh[lcrc_pkg::LIMIT_W-1:0];
        num_nxt = {num_r[lcrc_pkg::NUM_W-2:0], rem_ge};
        cnt_nxt = cnt_r - lcrc_pkg::CNT_W'(1);
      end
      lcrc_pkg::OP_LSTORE: begin
        // zero resistor or overflow saturates
        if ((rext_r == '0) || (num_r > lcrc_pkg::NUM_W'(lcrc_pkg::LIMIT_MAX))) begin
          limits_nxt[idx_r] = lcrc_pkg::LIMIT_MAX;
        end else begin
          limits_nxt[idx_r] = num_r[lcrc_pkg::LIMIT_W-1:0];
        end
        if (idx_r != lcrc_pkg::LAST_IDX) begin
          idx_nxt = idx_r + lcrc_pkg::SEL_W'(1);
        end
      end
      lcrc_pkg::OP_IDLE: begin
        if (in_xfer) begin
          load_nxt = in_tdata[lcrc_pkg::LOAD_W-1:0];
          idx_nxt  = '0;
        end
      end
      lcrc_pkg::OP_SCAN: begin
        if (!hit && (idx_r != lcrc_pkg::LAST_IDX)) begin
          idx_nxt = idx_r + lcrc_pkg::SEL_W'(1);
        end
      end
      lcrc_pkg::OP_CMUL: begin
        num_nxt = code_prod;
        den_nxt = en_r ? cur_limit : fixed_limit;
        rem_nxt = '0;
        cnt_nxt = lcrc_pkg::CNT_W'(lcrc_pkg::DIV_STEPS);
      end
      lcrc_pkg::OP_SETCODE: begin
        // quotient stays below full scale + 1 by construction
        code_nxt = num_r[lcrc_pkg::CODE_BITS-1:0];
        sel_nxt  = idx_r;
        stat_nxt = lcrc_pkg::ST_OK;
      end
      lcrc_pkg::OP_FIXED: begin
        idx_nxt = lcrc_pkg::LAST_IDX;
      end
      lcrc_pkg::OP_CLIP: begin
        code_nxt = lcrc_pkg::FULL_SCALE;
        sel_nxt  = lcrc_pkg::LAST_IDX;
        stat_nxt = lcrc_pkg::ST_CLIP;
      end
      lcrc_pkg::OP_ERR: begin
        code_nxt = '0;
        sel_nxt  = '0;
        stat_nxt = lcrc_pkg::ST_OVER;
      end
      lcrc_pkg::OP_OUT: begin
        if (!out_blocked) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, stat_r, sel_r, code_ext[11:8], code_ext[7:0]};
        end
      end
      default: begin
      end
    endcase

    // Writes to the three named registers restart the limit recompute program.
    if (cfg_wr_en) begin
      case (cfg_index)
        lcrc_pkg::REG_EXT_R: begin
          rext_nxt = cfg_wdata;
          pc_nxt   = lcrc_pkg::PC_REC_INIT;
        end
        lcrc_pkg::REG_VAR_MAX: begin
          vmax_nxt = cfg_wdata[lcrc_pkg::VMAX_W-1:0];
          pc_nxt   = lcrc_pkg::PC_REC_INIT;
        end
        lcrc_pkg::REG_EXT_EN: begin
          en_nxt = cfg_wdata[0];
          pc_nxt = lcrc_pkg::PC_REC_INIT;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= lcrc_pkg::PC_REC_INIT;
      out_valid_r <= 1'b0;
      rext_r      <= 20'd60000;
      vmax_r      <= 16'd60000;
      en_r        <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      rext_r      <= rext_nxt;
      vmax_r      <= vmax_nxt;
      en_r        <= en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    load_r     <= load_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    cnt_r      <= cnt_nxt;
    limits_r   <= limits_nxt;
    code_r     <= code_nxt;
    sel_r      <= sel_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

### dv/led_current_range_and_code_unit_tb.sv
// Self-checking testbench for the LED current range and code unit.
module led_current_range_and_code_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // No named register lives at this index; writes to it must be dropped
  localparam logic [lcrc_pkg::CIDX_W-1:0] REG_SPARE = 2'd3;

  // Idle cycles without any transfer before the run is declared hung.
  // Worst case is a register write with its limit recompute, plus long stalls.
  localparam int WATCHDOG_LIMIT = 4000;
  // Quiet cycles after the last result
  localparam int SETTLE_CYCLES  = 60;

  // Expected result of one load request, with the load kept for messages
  typedef struct packed {
    logic [lcrc_pkg::LOAD_W-1:0]  load;
    logic [lcrc_pkg::STAT_W-1:0]  status;
    logic [6:0]                   set1;
    logic [7:0]                   set0;
  } code_word_t;

  // Shadow of the unit: its registers, the scaled limit table, and the
  // codes it still owes on the output channel
  class current_code_model;
    logic [lcrc_pkg::REXT_W-1:0]  ext_r;
    logic [lcrc_pkg::VMAX_W-1:0]  vmax;
    logic                         ext_en;
    logic [lcrc_pkg::LIMIT_W-1:0] limits[lcrc_pkg::NUM_RANGES];
    code_word_t                   owed[$];
    int                           errors;

    function new();
      ext_r  = 20'd60000;
      vmax   = 16'd60000;
      ext_en = 1'b0;
      errors = 0;
      rescale_limits();
    endfunction

    function int base_ua(int idx);
      case (idx)
        0:       return 5000;
        1:       return 10000;
        2:       return 15000;
        3:       return 20000;
        4:       return 23000;
        5:       return 25000;
        6:       return 30000;
        default: return 50000;
      endcase
    endfunction

    // limit = base * vmax / ext_r, saturating; zero resistor saturates all
    function void rescale_limits();
      logic [63:0] v;
      for (int i = 0; i < lcrc_pkg::NUM_RANGES; i++) begin
        if (ext_r == '0) begin
          limits[i] = lcrc_pkg::LIMIT_MAX;
        end else begin
          v = 64'(base_ua(i)) * 64'(vmax) / 64'(ext_r);
          limits[i] = (v > 64'(lcrc_pkg::LIMIT_MAX)) ? lcrc_pkg::LIMIT_MAX
                                                      : v[lcrc_pkg::LIMIT_W-1:0];
        end
      end
    endfunction

    function void set_reg(logic [lcrc_pkg::CIDX_W-1:0] idx,
                          logic [lcrc_pkg::REXT_W-1:0] val);
      case (idx)
        lcrc_pkg::REG_EXT_R:   ext_r  = val;
        lcrc_pkg::REG_VAR_MAX: vmax   = val[lcrc_pkg::VMAX_W-1:0];
        lcrc_pkg::REG_EXT_EN:  ext_en = val[0];
        default:               return;
      endcase
      rescale_limits();
    endfunction

    function void note_load(logic [lcrc_pkg::LOAD_W-1:0] load);
      code_word_t  w;
      logic [63:0] lim;
      logic [63:0] code;
      int          sel;
      bit          hit;
      w      = '0;
      w.load = load;
      hit    = 1'b0;
      sel    = lcrc_pkg::NUM_RANGES - 1;
      if (ext_en) begin
        // first limit strictly above the request; a zero limit never wins
        for (int i = 0; i < lcrc_pkg::NUM_RANGES; i++) begin
          if (!hit && load < limits[i]) begin
            sel = i;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          w.status = lcrc_pkg::ST_OVER;
          owed.push_back(w);
          return;
        end
        lim  = 64'(limits[sel]);
        code = 64'(lcrc_pkg::FULL_SCALE) * 64'(load) / lim;
      end else begin
        lim = 64'(base_ua(sel));
        if (64'(load) > lim) begin
          code     = 64'(lcrc_pkg::FULL_SCALE);
          w.status = lcrc_pkg::ST_CLIP;
        end else begin
          code = 64'(lcrc_pkg::FULL_SCALE) * 64'(load) / lim;
        end
      end
      w.set0 = code[7:0];
      w.set1 = {3'(sel), code[11:8]};
      owed.push_back(w);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(logic [23:0] data);
      code_word_t w;
      if (owed.size() == 0) begin
        report($sformatf("result %h with no request outstanding", data));
        return;
      end
      w = owed.pop_front();
      if (data[7:0] !== w.set0)
        report($sformatf("load %0d: set0 %h, want %h", w.load, data[7:0], w.set0));
      if (data[14:8] !== w.set1)
        report($sformatf("load %0d: set1 %h, want %h", w.load, data[14:8], w.set1));
      if (data[16:15] !== w.status)
        report($sformatf("load %0d: status %0d, want %0d", w.load, data[16:15], w.status));
    endtask

    function int codes_owed();
      return owed.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_wr_en  = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [19:0] cfg_wdata  = '0;

  current_code_model model;
  bit                calm;          // no idling on either side while set
  int                stall_left;
  int                idle_cycles;

  led_current_range_and_code_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then a long one
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Loads aimed at the range boundaries, plus uniform and extreme values
  function automatic logic [lcrc_pkg::LOAD_W-1:0] pick_load();
    longint v;
    int     i;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        i = $urandom_range(0, lcrc_pkg::NUM_RANGES - 1);
        v = model.ext_en ? longint'(model.limits[i])
                         : longint'(model.base_ua(lcrc_pkg::NUM_RANGES - 1));
        v = v + longint'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > longint'(lcrc_pkg::LIMIT_MAX)) v = longint'(lcrc_pkg::LIMIT_MAX);
        return v[lcrc_pkg::LOAD_W-1:0];
      end
      4, 5, 6: return lcrc_pkg::LOAD_W'($urandom);
      7, 8:    return lcrc_pkg::LOAD_W'($urandom_range(0, 60000));
      default: return $urandom_range(0, 1) ? lcrc_pkg::LIMIT_MAX : '0;
    endcase
  endfunction

  // Transfer monitors: values read at the edge are the pre-edge ones
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) model.note_load(in_tdata[lcrc_pkg::LOAD_W-1:0]);
    if (rst_n && out_tvalid && out_tready) model.check_result(out_tdata);
  end

  // Result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      out_tready <= (stall_left == 0);
    end
  end

  // Watchdog: any transfer or register write counts as progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** led_current_range_and_code_unit: FAILED **");
        $finish;
      end
    end
  end

  // Hold a load on the input until it is transferred
  task automatic send_load(input logic [lcrc_pkg::LOAD_W-1:0] load);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, load};
    do @(posedge clk); while (!in_tready);
  endtask

  // Register write, then wait out the limit recompute it may start
  task automatic program_reg(input logic [lcrc_pkg::CIDX_W-1:0] idx,
                             input logic [19:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model.set_reg(idx, val);
    repeat (2) @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic configure(input logic [19:0] r, input logic [15:0] vmax, input logic en);
    program_reg(lcrc_pkg::REG_EXT_R, r);
    program_reg(lcrc_pkg::REG_VAR_MAX, 20'(vmax));
    program_reg(lcrc_pkg::REG_EXT_EN, 20'(en));
  endtask

  // Stop sending until every owed result is back, then let the unit settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (model.codes_owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int n, input bit no_idle);
    calm = no_idle;
    for (int k = 0; k < n; k++) begin
      // mid-phase pause with the pipe fully empty
      if (k == n / 2) drain();
      send_load(pick_load());
    end
    drain();
    calm = 1'b0;
  endtask

  initial begin
    model = new();
    calm  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // reset runs the limit recompute before the input opens
    do @(posedge clk); while (!in_tready);

    // Fixed 50 mA range at reset: zero, mid, at limit, just above (clip), max
    send_load(22'd0);       send_load(22'd1);       send_load(22'd25000);
    send_load(22'd49999);   send_load(22'd50000);   send_load(22'd50001);
    send_load(22'h3FFFFF);  send_load(22'h155555);  send_load(22'h2AAAAA);
    drain();

    // Scaled mode with unit ratio: limits equal the base table
    configure(20'd60000, 16'd60000, 1'b1);
    send_load(22'd0);       send_load(22'd4999);    send_load(22'd5000);
    send_load(22'd29999);   send_load(22'd30000);   send_load(22'd49999);
    send_load(22'd50000);   send_load(22'h3FFFFF);
    drain();

    // Zero resistor: every limit saturates, so only the all-ones load misses
    configure(20'd0, 16'd40000, 1'b1);
    send_load(22'h3FFFFE);  send_load(22'h3FFFFF);
    drain();

    // Zero variant max: all limits are zero, every request exceeds
    configure(20'hFFFFF, 16'd0, 1'b1);
    // spare index must leave the registers alone
    program_reg(REG_SPARE, 20'hFFFFF);
    send_load(22'd0);       send_load(22'd123);
    drain();

    // Tiny resistor: products overflow the limit width and saturate
    configure(20'd1, 16'hFFFF, 1'b1);
    send_load(22'd0);       send_load(22'h3FFFFF);
    drain();

    // Random loads over a spread of settings
    configure(20'd60000, 16'd60000, 1'b1);
    random_phase(36, 1'b0);
    configure(20'd1000, 16'd60000, 1'b1);
    random_phase(36, 1'b1);
    configure(20'hFFFFF, 16'hFFFF, 1'b1);
    random_phase(36, 1'b0);
    configure(20'd40000, 16'd40000, 1'b1);
    random_phase(36, 1'b0);
    configure(20'd1000000, 16'd40000, 1'b1);
    random_phase(36, 1'b0);
    repeat (3) begin
      configure(20'($urandom_range(1000, 1000000)), 16'($urandom_range(40000, 60000)), 1'b1);
      random_phase(36, 1'b0);
    end
    configure(20'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
    random_phase(36, 1'b1);
    configure(20'($urandom), 16'($urandom), 1'b0);
    random_phase(36, 1'b0);
    configure(20'd0, 16'd0, 1'b1);
    random_phase(20, 1'b0);

    drain();
    if (model.errors == 0) begin
      $display("** led_current_range_and_code_unit: PASSED **");
    end else begin
      $display("** led_current_range_and_code_unit: FAILED **");
    end
    $finish;
  end

endmodule
